// ----- sv/tatemp_pkg.sv -----
package tatemp_pkg;

	localparam int SAMPLES_PER_READING = 10;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 18;
	localparam int CNT_W    = $clog2(SAMPLES_PER_READING + 1);
	localparam int TEMP_W   = 17;
	localparam int RES_W    = 20;
	localparam int BETA_W   = 14;
	localparam int T0_W     = 15;
	localparam int IDX_W    = 2;

	localparam logic [SUM_W-1:0] FULL_SUM = SUM_W'(SAMPLES_PER_READING * 4095);

	// register indexes
	localparam logic [IDX_W-1:0] REG_SERIES  = 2'd0;
	localparam logic [IDX_W-1:0] REG_NOMINAL = 2'd1;
	localparam logic [IDX_W-1:0] REG_BETA    = 2'd2;
	localparam logic [IDX_W-1:0] REG_T0      = 2'd3;

	localparam int DIV_W = 48;
	localparam logic [27:0] LN2_Q28 = 28'd186065279;
	localparam logic [DIV_W-1:0] NUM_K = DIV_W'(100) << 40;
	localparam logic [16:0] KELVIN_OFS = 17'd27315;
	localparam logic [DIV_W-1:0] TK_MAX = DIV_W'(77315);
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 17'sd50000;

	typedef struct packed {
		logic [RES_W-1:0]       series;
		logic [RES_W-1:0]       nominal;
		logic [BETA_W-1:0]      beta;
		logic signed [T0_W-1:0] t0;
	} cfg_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic                     fault;
	} result_t;

	// sum queue handshake between front and back
	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
	} sumq_t;

endpackage

// ----- sv/tatemp_front.sv -----
module tatemp_front
	import tatemp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [SAMPLE_W-1:0] adc_sample,
	output sumq_t               sq,
	input  logic                sq_pop
);

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] ent_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       fill_q;
	logic             acc, last, wr, rd;
	logic [SUM_W-1:0] nsum;

	assign full = (fill_q == 2'd2);
	assign acc  = push && !full;
	assign nsum = sum_q + SUM_W'(adc_sample);
	assign last = (cnt_q == CNT_W'(SAMPLES_PER_READING - 1));
	assign wr   = acc && last;
	assign rd   = sq_pop && (fill_q != 2'd0);

	assign sq.valid = (fill_q != 2'd0);
	assign sq.sum   = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			cnt_q  <= '0;
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (acc) begin
				if (last) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= nsum;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			fill_q <= fill_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) ent_q[wp_q] <= nsum;
	end

endmodule

// ----- sv/tatemp_div.sv -----
module tatemp_div
	import tatemp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output logic             done,
	output logic [DIV_W-1:0] quo
);

	// restoring division, one quotient bit per cycle
	logic             busy_q, done_q;
	logic [5:0]       cnt_q;
	logic [DIV_W-1:0] n_q, d_q;
	logic [DIV_W-1:0] r_q;
	logic [DIV_W:0]   r2, diff;
	logic             ge;

	assign r2   = {r_q, n_q[DIV_W-1]};
	assign diff = r2 - {1'b0, d_q};
	assign ge   = (r2 >= {1'b0, d_q});
	assign done = done_q;
	assign quo  = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
			n_q <= {n_q[DIV_W-2:0], ge};
		end
	end

endmodule

// ----- sv/tatemp_back.sv -----
module tatemp_back
	import tatemp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  sumq_t                    sq,
	output logic                     sq_pop,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [TEMP_W-1:0] temperature_centi,
	output logic                     sensor_fault
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_XMUL = 4'd1;
	localparam logic [3:0] ST_NORM = 4'd2;
	localparam logic [3:0] ST_SQ   = 4'd3;
	localparam logic [3:0] ST_RND  = 4'd4;
	localparam logic [3:0] ST_DIFF = 4'd5;
	localparam logic [3:0] ST_MUL1 = 4'd6;
	localparam logic [3:0] ST_MUL2 = 4'd7;
	localparam logic [3:0] ST_LN   = 4'd8;
	localparam logic [3:0] ST_WB   = 4'd9;
	localparam logic [3:0] ST_WI   = 4'd10;
	localparam logic [3:0] ST_INV  = 4'd11;
	localparam logic [3:0] ST_WT   = 4'd12;

	logic [3:0]       st_q;
	logic [SUM_W-1:0] s_q;
	logic             which_q;
	logic [37:0]      x_q;
	logic [5:0]       e_q;
	logic [30:0]      m_q;
	logic [61:0]      p_q;
	logic [27:0]      fr_q;
	logic [4:0]       rnd_q;
	logic [33:0]      la_q, lb_q, dmag_q;
	logic             neg_q;
	logic [44:0]      pp_q;
	logic [61:0]      acc_q;
	logic [DIV_W-1:0] bmag_q;
	logic signed [DIV_W:0] inv_q;

	// result queue
	result_t    rq_q [2];
	logic       rwp_q, rrp_q;
	logic [1:0] rfill_q;
	logic       rq_wr, rq_rd;
	result_t    rq_din;

	logic [RES_W-1:0]  rs, r0;
	logic [BETA_W-1:0] bb;
	logic [16:0]       t0k;
	logic [5:0]        msb;
	logic [30:0]       mnorm;
	logic [31:0]       mm;
	logic [27:0]       fr_n;
	logic [62:0]       lnr;
	logic [33:0]       lnmag;
	logic signed [DIV_W:0] inv_n;
	logic              dv_start, dv_done;
	logic [DIV_W-1:0]  dv_num, dv_den, dv_q;
	logic              is_fault;

	assign rs  = (cfg.series == '0) ? RES_W'(1) : cfg.series;
	assign r0  = (cfg.nominal == '0) ? RES_W'(1) : cfg.nominal;
	assign bb  = (cfg.beta == '0) ? BETA_W'(1) : cfg.beta;
	assign t0k = 17'(signed'(17'(cfg.t0)) + signed'(KELVIN_OFS));

	assign is_fault = (sq.sum == '0) || (sq.sum >= FULL_SUM);

	always_comb begin
		msb = '0;
		for (int i = 0; i < 38; i++) begin
			if (x_q[i]) msb = 6'(i);
		end
	end

	always_comb begin
		if (msb > 6'd30) mnorm = 31'(x_q >> (msb - 6'd30));
		else mnorm = 31'(x_q << (6'd30 - msb));
	end

	assign mm    = p_q[61:30];
	assign fr_n  = {fr_q[26:0], mm[31]};
	assign lnr   = {1'b0, acc_q} + 63'(1 << 27);
	assign lnmag = lnr[61:28];
	assign inv_n = neg_q ? ($signed({1'b0, dv_q}) - $signed({1'b0, bmag_q}))
	                     : ($signed({1'b0, dv_q}) + $signed({1'b0, bmag_q}));

	always_comb begin
		dv_start = 1'b0;
		dv_num   = '0;
		dv_den   = '0;
		unique case (st_q)
			ST_LN: begin
				dv_start = 1'b1;
				dv_num   = {2'b0, lnmag, 12'b0} + DIV_W'(bb >> 1);
				dv_den   = DIV_W'(bb);
			end
			ST_WB: begin
				dv_start = dv_done;
				dv_num   = NUM_K + DIV_W'(t0k >> 1);
				dv_den   = DIV_W'(t0k);
			end
			ST_INV: begin
				dv_start = !(inv_q <= 0);
				dv_num   = NUM_K + inv_q[DIV_W:1];
				dv_den   = inv_q[DIV_W-1:0];
			end
			default: begin
				dv_start = 1'b0;
			end
		endcase
	end

	tatemp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (dv_den),
		.done   (dv_done),
		.quo    (dv_q)
	);

	assign sq_pop = (st_q == ST_IDLE) && sq.valid && (rfill_q != 2'd2);

	always_comb begin
		rq_wr  = 1'b0;
		rq_din = '{temp: '0, fault: 1'b0};
		unique case (st_q)
			ST_IDLE: begin
				rq_wr  = sq_pop && is_fault;
				rq_din = '{temp: '0, fault: 1'b1};
			end
			ST_INV: begin
				rq_wr  = (inv_q <= 0);
				rq_din = '{temp: TEMP_MAX, fault: 1'b0};
			end
			ST_WT: begin
				rq_wr = dv_done;
				if (dv_q > TK_MAX) rq_din.temp = TEMP_MAX;
				else rq_din.temp = signed'(TEMP_W'(dv_q) - TEMP_W'(KELVIN_OFS));
			end
			default: begin
				rq_wr = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: if (sq_pop && !is_fault) st_q <= ST_XMUL;
				ST_XMUL: st_q <= ST_NORM;
				ST_NORM: st_q <= ST_SQ;
				ST_SQ:   st_q <= ST_RND;
				ST_RND: begin
					if (rnd_q == 5'd27) st_q <= which_q ? ST_DIFF : ST_XMUL;
					else st_q <= ST_SQ;
				end
				ST_DIFF: st_q <= ST_MUL1;
				ST_MUL1: st_q <= ST_MUL2;
				ST_MUL2: st_q <= ST_LN;
				ST_LN:   st_q <= ST_WB;
				ST_WB:   if (dv_done) st_q <= ST_WI;
				ST_WI:   if (dv_done) st_q <= ST_INV;
				ST_INV:  st_q <= (inv_q <= 0) ? ST_IDLE : ST_WT;
				ST_WT:   if (dv_done) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				s_q     <= sq.sum;
				which_q <= 1'b0;
			end
			ST_XMUL: begin
				if (!which_q) x_q <= rs * s_q;
				else x_q <= r0 * (FULL_SUM - s_q);
			end
			ST_NORM: begin
				e_q   <= msb;
				m_q   <= mnorm;
				rnd_q <= '0;
			end
			ST_SQ: p_q <= m_q * m_q;
			ST_RND: begin
				m_q   <= mm[31] ? mm[31:1] : mm[30:0];
				fr_q  <= fr_n;
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == 5'd27) begin
					if (!which_q) la_q <= {e_q, fr_n};
					else lb_q <= {e_q, fr_n};
					which_q <= 1'b1;
				end
			end
			ST_DIFF: begin
				neg_q  <= lb_q > la_q;
				dmag_q <= (lb_q > la_q) ? lb_q - la_q : la_q - lb_q;
			end
			ST_MUL1: pp_q <= dmag_q[16:0] * LN2_Q28;
			ST_MUL2: acc_q <= 62'(pp_q) + (62'(dmag_q[33:17] * LN2_Q28) << 17);
			ST_WB:   if (dv_done) bmag_q <= dv_q;
			ST_WI:   if (dv_done) inv_q <= inv_n;
			default: begin
			end
		endcase
	end

	// result queue
	assign rq_rd             = pop && (rfill_q != 2'd0);
	assign empty             = (rfill_q == 2'd0);
	assign temperature_centi = rq_q[rrp_q].temp;
	assign sensor_fault      = rq_q[rrp_q].fault;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwp_q   <= 1'b0;
			rrp_q   <= 1'b0;
			rfill_q <= '0;
		end else begin
			if (rq_wr) rwp_q <= ~rwp_q;
			if (rq_rd) rrp_q <= ~rrp_q;
			rfill_q <= rfill_q + {1'b0, rq_wr} - {1'b0, rq_rd};
		end
	end

	always_ff @(posedge clk) begin
		if (rq_wr) rq_q[rwp_q] <= rq_din;
	end

endmodule

// ----- sv/thermistor_average_to_temperature.sv -----
// channel   | handshake        | payload
// samples   | push / full      | adc_sample
// results   | empty / pop      | temperature_centi, sensor_fault
// config    | cfg_we           | cfg_index, cfg_data
// A sample is taken while full is low; the front sums a group and hands the
// sum to the back through a two-word queue. The back runs two 28-round log2
// loops on one 31x31 squarer and up to three divisions on one shared restoring
// divider, the third skipped when the inverse is not positive. Faulted groups
// enter the result queue from idle. Reset clears sum, count and both queues.
// full rises when two sums wait; the back stalls while two results wait.
module thermistor_average_to_temperature
	import tatemp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [SAMPLE_W-1:0]      adc_sample,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [TEMP_W-1:0] temperature_centi,
	output logic                     sensor_fault,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [RES_W-1:0]         cfg_data
);

	cfg_t  cfg_q;
	sumq_t sq;
	logic  sq_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.series  <= RES_W'(10000);
			cfg_q.nominal <= RES_W'(10000);
			cfg_q.beta    <= BETA_W'(3950);
			cfg_q.t0      <= T0_W'(2500);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SERIES:  cfg_q.series  <= cfg_data;
				REG_NOMINAL: cfg_q.nominal <= cfg_data;
				REG_BETA:    cfg_q.beta    <= cfg_data[BETA_W-1:0];
				REG_T0:      cfg_q.t0      <= cfg_data[T0_W-1:0];
				default:     cfg_q.t0      <= cfg_q.t0;
			endcase
		end
	end

	tatemp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.adc_sample (adc_sample),
		.sq         (sq),
		.sq_pop     (sq_pop)
	);

	tatemp_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.sq                (sq),
		.sq_pop            (sq_pop),
		.empty             (empty),
		.pop               (pop),
		.temperature_centi (temperature_centi),
		.sensor_fault      (sensor_fault)
	);

endmodule

// ----- tb/sv/thermistor_average_to_temperature_tb.sv -----
`timescale 1ns / 100ps

module thermistor_average_to_temperature_tb;
	import tatemp_pkg::*;

	localparam int TEMP_MIN   = -27315;
	localparam int FULL_SCALE = SAMPLES_PER_READING * 4095;
	localparam int SETTLE     = 400;
	localparam int STUCK_MAX  = 20000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     push = 1'b0;
	logic                     full;
	logic [SAMPLE_W-1:0]      adc_sample = '0;
	logic                     empty;
	logic                     pop = 1'b0;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic                     sensor_fault;
	logic                     cfg_we = 1'b0;
	logic [IDX_W-1:0]         cfg_index = REG_SERIES;
	logic [RES_W-1:0]         cfg_data = '0;

	thermistor_average_to_temperature dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// local copy of the registers and the group accumulator
	logic [RES_W-1:0]       series_ohms = 20'd10000;
	logic [RES_W-1:0]       nominal_ohms = 20'd10000;
	logic [BETA_W-1:0]      beta_k = 14'd3950;
	logic signed [T0_W-1:0] t0_centi = 15'sd2500;
	logic [SUM_W-1:0]       group_sum = '0;
	int                     group_cnt = 0;

	logic [SAMPLE_W-1:0] sample_q[$];
	result_t             temp_q[$];
	int                  errors = 0;
	bit                  quiet = 1'b0;
	int                  in_gap = 0;
	int                  out_gap = 0;
	int                  stuck = 0;

	// log2 in Q.28 by repeated squaring of a Q1.30 mantissa
	function automatic logic [63:0] log2_q28(logic [63:0] x);
		int          e;
		logic [63:0] t, m, r;
		e = 0;
		t = x;
		while (t > 1) begin
			t >>= 1;
			e++;
		end
		m = (e > 30) ? (x >> (e - 30)) : (x << (30 - e));
		r = 64'(e) << 28;
		for (int i = 27; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m >>= 1;
				r[i] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] div_round(logic [63:0] n, logic [63:0] d);
		return (n + d / 2) / d;
	endfunction

	function automatic longint beta_temp(logic [63:0] s);
		logic [63:0] rs, r0, b, la, lb, dmag, lnmag, bmag, num;
		bit          neg;
		longint      inv, tc;
		rs = (series_ohms == 0) ? 64'd1 : 64'(series_ohms);
		r0 = (nominal_ohms == 0) ? 64'd1 : 64'(nominal_ohms);
		b  = (beta_k == 0) ? 64'd1 : 64'(beta_k);
		la = log2_q28(rs * s);
		lb = log2_q28(r0 * (64'(FULL_SCALE) - s));
		neg = lb > la;
		dmag = neg ? lb - la : la - lb;
		lnmag = (dmag * 64'(LN2_Q28) + (64'd1 << 27)) >> 28;
		bmag = div_round(lnmag << 12, b);
		num = 64'd100 << 40;
		inv = longint'(div_round(num, 64'(longint'(t0_centi) + 27315)));
		inv = neg ? inv - longint'(bmag) : inv + longint'(bmag);
		if (inv <= 0)
			return 50000;
		tc = longint'(div_round(num, 64'(inv))) - 27315;
		if (tc > 50000) tc = 50000;
		if (tc < TEMP_MIN) tc = TEMP_MIN;
		return tc;
	endfunction

	function automatic void add_sample(logic [SAMPLE_W-1:0] a);
		result_t r;
		group_sum = group_sum + SUM_W'(a);
		group_cnt++;
		if (group_cnt < SAMPLES_PER_READING)
			return;
		if (group_sum == 0 || group_sum >= FULL_SUM) begin
			r.temp = '0;
			r.fault = 1'b1;
		end else begin
			r.temp = TEMP_W'(beta_temp(64'(group_sum)));
			r.fault = 1'b0;
		end
		temp_q.push_back(r);
		group_sum = '0;
		group_cnt = 0;
	endfunction

	always @(negedge clk) begin
		if (in_gap > 0) begin
			in_gap--;
			push <= 1'b0;
		end else if (sample_q.size() > 0) begin
			push <= 1'b1;
			adc_sample <= sample_q[0];
			if (!quiet && $urandom_range(0, 11) == 0)
				in_gap = $urandom_range(1, 15);
		end else begin
			push <= 1'b0;
		end
		if (out_gap > 0) begin
			out_gap--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			if (!quiet && $urandom_range(0, 7) == 0)
				out_gap = $urandom_range(1, 15);
		end
	end

	always @(posedge clk) begin
		result_t e;
		bit      moved;
		if (arst_n) begin
			moved = cfg_we;
			if (push && !full) begin
				void'(sample_q.pop_front());
				add_sample(adc_sample);
				moved = 1'b1;
			end
			if (pop && !empty) begin
				moved = 1'b1;
				if (temp_q.size() == 0) begin
					$error("unexpected word: temperature_centi %0d sensor_fault %0b",
						temperature_centi, sensor_fault);
					errors++;
				end else begin
					e = temp_q.pop_front();
					if (temperature_centi !== e.temp) begin
						$error("temperature_centi: expected %0d, got %0d",
							e.temp, temperature_centi);
						errors++;
					end
					if (sensor_fault !== e.fault) begin
						$error("sensor_fault: expected %0b, got %0b", e.fault, sensor_fault);
						errors++;
					end
				end
			end
			stuck <= moved ? 0 : stuck + 1;
			if (stuck >= STUCK_MAX) begin
				$display("FAIL thermistor_average_to_temperature");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [RES_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		unique case (idx)
			REG_SERIES:  series_ohms = v;
			REG_NOMINAL: nominal_ohms = v;
			REG_BETA:    beta_k = v[BETA_W-1:0];
			REG_T0:      t0_centi = v[T0_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_cfg(int rs, int r0, int b, int t0);
		write_reg(REG_SERIES, RES_W'(rs));
		write_reg(REG_NOMINAL, RES_W'(r0));
		write_reg(REG_BETA, RES_W'(b));
		write_reg(REG_T0, RES_W'(t0));
	endtask

	// one group around a level; noise 4096 gives uniform words
	task automatic queue_group(int lvl, int noise);
		int v;
		for (int i = 0; i < SAMPLES_PER_READING; i++) begin
			if (noise >= 4096)
				v = $urandom_range(0, 4095);
			else
				v = lvl + $urandom_range(0, 2 * noise) - noise;
			if (v < 0) v = 0;
			if (v > 4095) v = 4095;
			sample_q.push_back(SAMPLE_W'(v));
		end
	endtask

	task automatic random_groups(int n);
		int k;
		for (int g = 0; g < n; g++) begin
			k = $urandom_range(0, 19);
			if (k < 6)
				queue_group(0, 4096);
			else if (k < 8)
				queue_group($urandom_range(0, 3), 2);
			else if (k < 10)
				queue_group($urandom_range(4092, 4095), 2);
			else if (k == 10)
				queue_group(0, 0);
			else if (k == 11)
				queue_group(4095, 0);
			else
				queue_group($urandom_range(0, 4095), $urandom_range(0, 40));
		end
	endtask

	task automatic drain;
		while (sample_q.size() > 0 || temp_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: faults at both ends, smallest and largest nonfault sums
		queue_group(0, 0);
		queue_group(4095, 0);
		sample_q.push_back(12'd1);
		repeat (SAMPLES_PER_READING - 1) sample_q.push_back(12'd0);
		sample_q.push_back(12'd4094);
		repeat (SAMPLES_PER_READING - 1) sample_q.push_back(12'd4095);
		drain();

		set_cfg(1, 1000000, 1000, -5000);
		random_groups(11);
		drain();

		set_cfg(1000000, 1, 10000, 15000);
		random_groups(11);
		drain();

		// zero registers act as one; out-of-range beta and temperature as given
		set_cfg(0, 0, 0, -16384);
		random_groups(8);
		drain();
		set_cfg(1048575, 1048575, 16383, 16383);
		random_groups(8);
		drain();

		for (int p = 0; p < 3; p++) begin
			set_cfg($urandom_range(0, 1048575), $urandom_range(0, 1048575),
				$urandom_range(0, 16383), $urandom_range(0, 32767));
			random_groups(6);
			drain();
		end

		quiet = 1'b1;
		set_cfg($urandom_range(1, 1000000), $urandom_range(1, 1000000),
			$urandom_range(1000, 10000), $urandom_range(0, 20000) - 5000);
		random_groups(6);
		drain();

		if (errors == 0)
			$display("PASS thermistor_average_to_temperature");
		else
			$display("FAIL thermistor_average_to_temperature");
		$finish;
	end

endmodule
